>>> rtl/core/gbfs_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// gbfs_pkg: shared types and constants for the grid BFS shortest-path block
// Request/result words, configuration register map, FSM states and the
// command/status groups between controller and datapath.
// ----------------------------------------------------------------------------
package gbfs_pkg;

  localparam int GRID_SIDE_DEF = 16;

  // compare width for coordinates and bounds (covers GRID_SIDE up to 64)
  localparam int CMP_W  = 8;
  localparam int DIST_W = 8;
  localparam logic [DIST_W-1:0] DIST_MAX = '1;

  // configuration port
  localparam int CFG_AW = 3;
  localparam int CFG_DW = 5;

  localparam logic [CFG_AW-1:0] CFG_START_COL = 3'd0;
  localparam logic [CFG_AW-1:0] CFG_START_ROW = 3'd1;
  localparam logic [CFG_AW-1:0] CFG_GOAL_COL  = 3'd2;
  localparam logic [CFG_AW-1:0] CFG_GOAL_ROW  = 3'd3;
  localparam logic [CFG_AW-1:0] CFG_COLS      = 3'd4;
  localparam logic [CFG_AW-1:0] CFG_ROWS      = 3'd5;

  localparam logic [3:0] GOAL_RST = 4'd15;
  localparam logic [4:0] SIZE_RST = 5'd16;

  // request codes
  localparam logic [1:0] REQ_LOAD   = 2'd0;
  localparam logic [1:0] REQ_SEARCH = 2'd1;
  localparam logic [1:0] REQ_READ   = 2'd2;

  // neighbor visiting order
  localparam logic [1:0] DIR_RIGHT = 2'd0;
  localparam logic [1:0] DIR_DOWN  = 2'd1;
  localparam logic [1:0] DIR_LEFT  = 2'd2;
  localparam logic [1:0] DIR_UP    = 2'd3;

  typedef struct packed {
    logic [1:0] req_type;
    logic [3:0] cell_col;
    logic [3:0] cell_row;
    logic       cell_open;
  } req_item_t;

  typedef struct packed {
    logic              goal_reached;
    logic              cell_marked;
    logic [DIST_W-1:0] distance;
  } rsp_item_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_LOAD,
    ST_READ,
    ST_READ_CHK,
    ST_CLEAR,
    ST_INIT,
    ST_POP,
    ST_DEQ,
    ST_NB_RD,
    ST_NB_CHK,
    ST_RESP
  } gbfs_state_t;

  typedef struct packed {
    logic latch_req;
    logic load_wr;
    logic read_req;
    logic read_take;
    logic clear_step;
    logic push_start;
    logic pop_rd;
    logic deq_wr;
    logic goal_hit;
    logic nb_rd;
    logic nb_push;
    logic dir_next;
    logic out_load;
  } gbfs_cmd_t;

  typedef struct packed {
    logic start_ok;
    logic clr_last;
    logic fifo_empty;
    logic at_goal;
    logic nb_in;
    logic nb_take;
    logic dir_last;
  } gbfs_sts_t;

endpackage
`default_nettype wire

>>> rtl/core/gbfs_req_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// gbfs_req_if: request channel
// valid/ready handshake carrying one request word.
// ----------------------------------------------------------------------------
interface gbfs_req_if;
  logic                valid;
  logic                ready;
  gbfs_pkg::req_item_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

>>> rtl/core/gbfs_rsp_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// gbfs_rsp_if: result channel
// valid/ready handshake carrying one result word.
// ----------------------------------------------------------------------------
interface gbfs_rsp_if;
  logic                valid;
  logic                ready;
  gbfs_pkg::rsp_item_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

>>> rtl/core/gbfs_ram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// gbfs_ram: generic simple dual-port RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module gbfs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

>>> rtl/core/gbfs_dpath.sv
`default_nettype none
// ----------------------------------------------------------------------------
// gbfs_dpath: grid BFS datapath
// Configuration registers, open map, mark map (done/seen/distance), cell
// FIFO, neighbor generation, bounds checks and the result register.
// ----------------------------------------------------------------------------
module gbfs_dpath #(
  parameter int GRID_SIDE = gbfs_pkg::GRID_SIDE_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_we,
  input  logic [gbfs_pkg::CFG_AW-1:0] cfg_addr,
  input  logic [gbfs_pkg::CFG_DW-1:0] cfg_wdata,
  input  gbfs_pkg::req_item_t         req_data,
  input  gbfs_pkg::gbfs_cmd_t         cmd,
  output gbfs_pkg::gbfs_sts_t         sts,
  output gbfs_pkg::rsp_item_t         rsp_data
);
  import gbfs_pkg::*;

  localparam int CW    = $clog2(GRID_SIDE);
  localparam int AW    = 2 * CW;
  localparam int DEPTH = 1 << AW;
  localparam int FW    = DIST_W + AW;
  localparam int MW    = DIST_W + 2;
  localparam logic [CMP_W-1:0] SIDE = CMP_W'(GRID_SIDE);

  // configuration
  logic [3:0] start_col, start_row, goal_col, goal_row;
  logic [4:0] cols_in_use, rows_in_use;

  // control counters
  logic [AW-1:0] clr_cnt;
  logic [AW:0]   head, tail;
  logic [1:0]    dir;
  logic          marks_valid;

  // payload
  req_item_t   req_q;
  rsp_item_t   res;

  logic [CMP_W-1:0] wc8, wr8, rq_col8, rq_row8, st_col8, st_row8;
  logic [CMP_W-1:0] c8, r8, nc8, nr8;
  logic [AW-1:0]    rq_addr, st_addr, cur_addr, nb_addr;
  logic             rq_in;
  logic [DIST_W-1:0] cur_dist, nd;

  logic          mark_we, mark_re, open_we, open_re, fifo_we, fifo_re;
  logic [AW-1:0] mark_wa, mark_ra, open_wa, open_ra, fifo_wa, fifo_ra;
  logic [MW-1:0] mark_wd, mark_rd;
  logic          open_wd, open_rd;
  logic [FW-1:0] fifo_wd, fifo_rd;

  // size registers clamp to the grid
  assign wc8 = (CMP_W'(cols_in_use) > SIDE) ? SIDE : CMP_W'(cols_in_use);
  assign wr8 = (CMP_W'(rows_in_use) > SIDE) ? SIDE : CMP_W'(rows_in_use);

  assign rq_col8 = CMP_W'(req_q.cell_col);
  assign rq_row8 = CMP_W'(req_q.cell_row);
  assign rq_in   = (rq_col8 < SIDE) && (rq_row8 < SIDE);
  assign rq_addr = {rq_row8[CW-1:0], rq_col8[CW-1:0]};

  assign st_col8 = CMP_W'(start_col);
  assign st_row8 = CMP_W'(start_row);
  assign st_addr = {st_row8[CW-1:0], st_col8[CW-1:0]};

  // FIFO word: {distance, row, col}
  assign cur_dist = fifo_rd[FW-1 -: DIST_W];
  assign cur_addr = fifo_rd[AW-1:0];
  assign c8       = CMP_W'(fifo_rd[CW-1:0]);
  assign r8       = CMP_W'(fifo_rd[AW-1:CW]);
  assign nd       = (cur_dist == DIST_MAX) ? DIST_MAX : cur_dist + DIST_W'(1);

  // stepping left/up from zero wraps high and fails the bounds check
  always_comb begin
    nc8 = c8;
    nr8 = r8;
    case (dir)
      DIR_RIGHT: nc8 = c8 + CMP_W'(1);
      DIR_DOWN:  nr8 = r8 + CMP_W'(1);
      DIR_LEFT:  nc8 = c8 - CMP_W'(1);
      DIR_UP:    nr8 = r8 - CMP_W'(1);
      default:   nc8 = c8;
    endcase
  end

  assign nb_addr = {nr8[CW-1:0], nc8[CW-1:0]};

  assign sts.start_ok   = (st_col8 < wc8) && (st_row8 < wr8);
  assign sts.clr_last   = &clr_cnt;
  assign sts.fifo_empty = (head == tail);
  assign sts.at_goal    = (c8 == CMP_W'(goal_col)) && (r8 == CMP_W'(goal_row));
  assign sts.nb_in      = (nc8 < wc8) && (nr8 < wr8);
  assign sts.nb_take    = open_rd && !mark_rd[DIST_W];
  assign sts.dir_last   = (dir == DIR_UP);

  always_ff @(posedge clk) begin
    if (rst) begin
      start_col   <= '0;
      start_row   <= '0;
      goal_col    <= GOAL_RST;
      goal_row    <= GOAL_RST;
      cols_in_use <= SIZE_RST;
      rows_in_use <= SIZE_RST;
      clr_cnt     <= '0;
      head        <= '0;
      tail        <= '0;
      dir         <= DIR_RIGHT;
      marks_valid <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_addr)
          CFG_START_COL: start_col   <= cfg_wdata[3:0];
          CFG_START_ROW: start_row   <= cfg_wdata[3:0];
          CFG_GOAL_COL:  goal_col    <= cfg_wdata[3:0];
          CFG_GOAL_ROW:  goal_row    <= cfg_wdata[3:0];
          CFG_COLS:      cols_in_use <= cfg_wdata;
          CFG_ROWS:      rows_in_use <= cfg_wdata;
          default:       ;
        endcase
      end
      if (cmd.latch_req) begin
        clr_cnt <= '0;
        head    <= '0;
        tail    <= '0;
      end
      if (cmd.clear_step) begin
        clr_cnt <= clr_cnt + AW'(1);
        if (&clr_cnt) begin
          marks_valid <= 1'b1;
        end
      end
      if (cmd.push_start || cmd.nb_push) begin
        tail <= tail + (AW+1)'(1);
      end
      if (cmd.pop_rd) begin
        head <= head + (AW+1)'(1);
      end
      if (cmd.deq_wr) begin
        dir <= DIR_RIGHT;
      end else if (cmd.dir_next) begin
        dir <= dir + 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.latch_req) begin
      req_q <= req_data;
      res   <= '0;
    end
    if (cmd.goal_hit) begin
      res.goal_reached <= 1'b1;
      res.distance     <= cur_dist;
    end
    if (cmd.read_take && rq_in && marks_valid && mark_rd[MW-1]) begin
      res.cell_marked <= 1'b1;
      res.distance    <= mark_rd[DIST_W-1:0];
    end
    if (cmd.out_load) begin
      rsp_data <= res;
    end
  end

  // mark word: {done, seen, distance}
  always_comb begin
    mark_we = cmd.clear_step | cmd.push_start | cmd.deq_wr | cmd.nb_push;
    mark_wa = clr_cnt;
    mark_wd = '0;
    if (cmd.push_start) begin
      mark_wa = st_addr;
      mark_wd = {1'b0, 1'b1, DIST_W'(0)};
    end else if (cmd.deq_wr) begin
      mark_wa = cur_addr;
      mark_wd = {1'b1, 1'b1, cur_dist};
    end else if (cmd.nb_push) begin
      mark_wa = nb_addr;
      mark_wd = {1'b0, 1'b1, DIST_W'(0)};
    end
    mark_re = cmd.read_req | cmd.nb_rd;
    mark_ra = cmd.read_req ? rq_addr : nb_addr;
  end

  assign open_we = cmd.load_wr && rq_in;
  assign open_wa = rq_addr;
  assign open_wd = req_q.cell_open;
  assign open_re = cmd.nb_rd;
  assign open_ra = nb_addr;

  assign fifo_we = cmd.push_start | cmd.nb_push;
  assign fifo_wa = tail[AW-1:0];
  assign fifo_wd = cmd.push_start ? {DIST_W'(0), st_addr} : {nd, nb_addr};
  assign fifo_re = cmd.pop_rd;
  assign fifo_ra = head[AW-1:0];

  gbfs_ram #(.WIDTH(MW), .DEPTH(DEPTH)) u_mark_ram (
    .clk   (clk),
    .we    (mark_we),
    .waddr (mark_wa),
    .wdata (mark_wd),
    .re    (mark_re),
    .raddr (mark_ra),
    .rdata (mark_rd)
  );

  gbfs_ram #(.WIDTH(1), .DEPTH(DEPTH)) u_open_ram (
    .clk   (clk),
    .we    (open_we),
    .waddr (open_wa),
    .wdata (open_wd),
    .re    (open_re),
    .raddr (open_ra),
    .rdata (open_rd)
  );

  gbfs_ram #(.WIDTH(FW), .DEPTH(DEPTH)) u_fifo_ram (
    .clk   (clk),
    .we    (fifo_we),
    .waddr (fifo_wa),
    .wdata (fifo_wd),
    .re    (fifo_re),
    .raddr (fifo_ra),
    .rdata (fifo_rd)
  );

endmodule
`default_nettype wire

>>> rtl/core/gbfs_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// gbfs_ctrl: grid BFS controller
// Sequences load, read and search requests over the datapath and owns the
// result word's valid flag.
// ----------------------------------------------------------------------------
module gbfs_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  input  logic [1:0]          in_type,
  output logic                in_ready,
  output logic                out_valid,
  input  logic                out_ready,
  input  gbfs_pkg::gbfs_sts_t sts,
  output gbfs_pkg::gbfs_cmd_t cmd
);
  import gbfs_pkg::*;

  gbfs_state_t state, state_next;
  logic        out_valid_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (in_valid) begin
          case (in_type)
            REQ_LOAD:   state_next = ST_LOAD;
            REQ_SEARCH: state_next = ST_CLEAR;
            REQ_READ:   state_next = ST_READ;
            default:    state_next = ST_RESP;
          endcase
        end
      end
      ST_LOAD:     state_next = ST_RESP;
      ST_READ:     state_next = ST_READ_CHK;
      ST_READ_CHK: state_next = ST_RESP;
      ST_CLEAR: begin
        if (sts.clr_last) state_next = ST_INIT;
      end
      ST_INIT:     state_next = sts.start_ok ? ST_POP : ST_RESP;
      ST_POP:      state_next = sts.fifo_empty ? ST_RESP : ST_DEQ;
      ST_DEQ:      state_next = sts.at_goal ? ST_RESP : ST_NB_RD;
      ST_NB_RD: begin
        if (sts.nb_in) begin
          state_next = ST_NB_CHK;
        end else if (sts.dir_last) begin
          state_next = ST_POP;
        end
      end
      ST_NB_CHK:   state_next = sts.dir_last ? ST_POP : ST_NB_RD;
      ST_RESP: begin
        if (!out_valid || out_ready) state_next = ST_IDLE;
      end
      default:     state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    case (state)
      ST_IDLE: begin
        in_ready      = 1'b1;
        cmd.latch_req = in_valid;
      end
      ST_LOAD:     cmd.load_wr    = 1'b1;
      ST_READ:     cmd.read_req   = 1'b1;
      ST_READ_CHK: cmd.read_take  = 1'b1;
      ST_CLEAR:    cmd.clear_step = 1'b1;
      ST_INIT:     cmd.push_start = sts.start_ok;
      ST_POP:      cmd.pop_rd     = !sts.fifo_empty;
      ST_DEQ: begin
        cmd.deq_wr   = 1'b1;
        cmd.goal_hit = sts.at_goal;
      end
      ST_NB_RD: begin
        cmd.nb_rd    = sts.nb_in;
        cmd.dir_next = !sts.nb_in;
      end
      ST_NB_CHK: begin
        cmd.nb_push  = sts.nb_take;
        cmd.dir_next = 1'b1;
      end
      ST_RESP:     cmd.out_load   = !out_valid || out_ready;
      default:     cmd = '0;
    endcase
  end

  always_comb begin
    if (cmd.out_load) begin
      out_valid_next = 1'b1;
    end else if (out_valid && out_ready) begin
      out_valid_next = 1'b0;
    end else begin
      out_valid_next = out_valid;
    end
  end

endmodule
`default_nettype wire

>>> rtl/core/grid_bfs_shortest_path.sv
`default_nettype none
// ----------------------------------------------------------------------------
// grid_bfs_shortest_path: breadth-first shortest path on a square cell grid
// Request channel (req) takes load, search and read words; every request
// gives exactly one word on the result channel (rsp).
//   load:   writes the open/wall bit of one cell.
//   read:   returns a cell's done mark and distance from the last search.
//   search: clears the marks (every map entry, 2^(2*clog2(GRID_SIDE))
//           entries, 256 for a 16x16 grid), then runs BFS from the start cell.
//           Neighbors of each dequeued cell are checked in turn (right, down,
//           left, up); the mark and open map single read ports set this pace,
//           and neighbors outside the area are skipped without a map read.
// One request is processed at a time. The result register lets the next
// request be taken while the previous result waits; a request finishing
// while rsp is still stalled waits until that word is taken.
// Reset (rst, synchronous) sets the registers to their reset values, empties
// the result register and leaves no marks visible; the open map holds nothing
// until loaded. Configuration writes (cfg_we) take effect from the next cycle.
// ----------------------------------------------------------------------------
module grid_bfs_shortest_path #(
  parameter int GRID_SIDE = gbfs_pkg::GRID_SIDE_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_we,
  input  logic [gbfs_pkg::CFG_AW-1:0] cfg_addr,
  input  logic [gbfs_pkg::CFG_DW-1:0] cfg_wdata,
  gbfs_req_if.sink                    req,
  gbfs_rsp_if.source                  rsp
);
  import gbfs_pkg::*;

  gbfs_cmd_t cmd;
  gbfs_sts_t sts;
  logic      in_ready, out_valid;

  gbfs_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (req.valid),
    .in_type   (req.data.req_type),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (rsp.ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  gbfs_dpath #(.GRID_SIDE(GRID_SIDE)) u_dpath (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .req_data  (req.data),
    .cmd       (cmd),
    .sts       (sts),
    .rsp_data  (rsp.data)
  );

  assign req.ready = in_ready;
  assign rsp.valid = out_valid;

  // one writer of the mark map per cycle
  a_mark_one_writer: assert property (@(posedge clk) disable iff (rst)
    $onehot0({cmd.clear_step, cmd.push_start, cmd.deq_wr, cmd.nb_push}))
    else $error("mark map written by more than one source");

  // a new result never overwrites one still waiting
  a_no_result_overwrite: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |-> (!rsp.valid || rsp.ready))
    else $error("result register overwritten while stalled");

  // the block goes busy after taking a request
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (req.valid && req.ready) |=> !req.ready)
    else $error("request taken while previous one in progress");

  // never dequeue from an empty FIFO
  a_no_pop_empty: assert property (@(posedge clk) disable iff (rst)
    cmd.pop_rd |-> !sts.fifo_empty)
    else $error("cell FIFO underflow");

endmodule
`default_nettype wire
